@@ rtl/rotation_matrix_to_quaternion_core_assert.svh @@
// Assertion macros for the rotation matrix to quaternion core.
`ifndef ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RMQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmq assertion failed");

// Next-cycle implication, checked during reset as well.
`define RMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rmq assertion failed");

`endif

@@ rtl/rmq_pkg.sv @@
// Shared types and constants of the rotation matrix to quaternion core.
package rmq_pkg;
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X = 2'd1;
  localparam logic [1:0] BR_Y = 2'd2;
  localparam logic [1:0] BR_Z = 2'd3;
  localparam int MAG_W = 32;
  localparam int NRM_W = 30;
  localparam int SQ_W = 62;
  localparam int ROOT_W = 31;
  localparam int QUO_W = 17;
  localparam int NUM_W = 61;

  typedef struct packed {
    logic [3:0] neg;
    logic [3:0] nz;
    logic [1:0] br;
    logic degen;
  } side_t;

  typedef logic [3:0][MAG_W-1:0] mag_vec_t;
  typedef logic [3:0][NRM_W-1:0] nrm_vec_t;
  typedef logic [3:0][QUO_W-1:0] quo_vec_t;
endpackage

@@ rtl/rmq_front.sv @@
// Branch selection, magnitude extraction and power-of-two normalization stages.
module rmq_front #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic vout,
  output rmq_pkg::side_t side_out,
  output rmq_pkg::nrm_vec_t nrm_out
);
  import rmq_pkg::*;

  localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;

  logic signed [33:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  logic signed [33:0] tr, t;
  logic signed [33:0] vv [4];
  logic [1:0] br;
  side_t side_c;
  mag_vec_t mag_c;

  logic v1, v2;
  side_t side1, side2;
  mag_vec_t mag1, mag2;
  logic [MAG_W-1:0] mx_c, mx2;
  logic [MAG_W-1:0] mx01, mx23;
  logic [4:0] p;
  nrm_vec_t nrm_c;

  assign a00 = 34'(m00);
  assign a01 = 34'(m01);
  assign a02 = 34'(m02);
  assign a10 = 34'(m10);
  assign a11 = 34'(m11);
  assign a12 = 34'(m12);
  assign a20 = 34'(m20);
  assign a21 = 34'(m21);
  assign a22 = 34'(m22);
  assign tr = a00 + a11 + a22;

  always_comb begin
    priority if (tr > 0) begin
      br = BR_TRACE;
      t = ONE + tr;
      vv[0] = t;
      vv[1] = a21 - a12;
      vv[2] = a02 - a20;
      vv[3] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_X;
      t = ONE + a00 - a11 - a22;
      vv[0] = a21 - a12;
      vv[1] = t;
      vv[2] = a01 + a10;
      vv[3] = a02 + a20;
    end else if (a11 > a22) begin
      br = BR_Y;
      t = ONE + a11 - a00 - a22;
      vv[0] = a02 - a20;
      vv[1] = a01 + a10;
      vv[2] = t;
      vv[3] = a12 + a21;
    end else begin
      br = BR_Z;
      t = ONE + a22 - a00 - a11;
      vv[0] = a10 - a01;
      vv[1] = a02 + a20;
      vv[2] = a12 + a21;
      vv[3] = t;
    end
  end

  always_comb begin
    side_c.br = br;
    side_c.degen = (t <= 0);
    for (int i = 0; i < 4; i++) begin
      side_c.neg[i] = vv[i] < 0;
      mag_c[i] = side_c.neg[i] ? MAG_W'(-vv[i]) : MAG_W'(vv[i]);
      side_c.nz[i] = (vv[i] != 0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      vout <= 1'b0;
    end else if (en) begin
      v1 <= vin;
      v2 <= v1;
      vout <= v2;
    end
  end

  assign mx01 = (mag1[1] > mag1[0]) ? mag1[1] : mag1[0];
  assign mx23 = (mag1[3] > mag1[2]) ? mag1[3] : mag1[2];
  assign mx_c = (mx23 > mx01) ? mx23 : mx01;

  always_comb begin
    p = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (mx2[b]) p = 5'(b);
    end
    for (int i = 0; i < 4; i++) begin
      if (p >= 5'd30) nrm_c[i] = NRM_W'(mag2[i] >> (p - 5'd29));
      else nrm_c[i] = NRM_W'(mag2[i] << (5'd29 - p));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= side_c;
      mag1 <= mag_c;
      side2 <= side1;
      mag2 <= mag1;
      mx2 <= mx_c;
      side_out <= side2;
      nrm_out <= nrm_c;
    end
  end
endmodule

@@ rtl/rmq_sqrt.sv @@
// Sum of squares and bit-per-stage integer square root pipeline.
module rmq_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  rmq_pkg::side_t side_in,
  input  rmq_pkg::nrm_vec_t nrm_in,
  output logic vout,
  output rmq_pkg::side_t side_out,
  output rmq_pkg::nrm_vec_t nrm_out,
  output logic [rmq_pkg::ROOT_W-1:0] root
);
  import rmq_pkg::*;

  localparam int DEPTH = ROOT_W + 2;

  logic [3:0][2*NRM_W-1:0] sq;
  logic [SQ_W-1:0] sum;
  logic vs [DEPTH];
  side_t ss [DEPTH];
  nrm_vec_t ns [DEPTH];
  logic [SQ_W-1:0] xs [ROOT_W+1];
  logic [SQ_W-1:0] rs [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vs[k] <= 1'b0;
    end else if (en) begin
      vs[0] <= vin;
      for (int k = 1; k < DEPTH; k++) vs[k] <= vs[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ss[0] <= side_in;
      ns[0] <= nrm_in;
      for (int k = 1; k < DEPTH; k++) begin
        ss[k] <= ss[k-1];
        ns[k] <= ns[k-1];
      end
      for (int i = 0; i < 4; i++) sq[i] <= nrm_in[i] * nrm_in[i];
      sum <= SQ_W'(sq[0]) + SQ_W'(sq[1]) + SQ_W'(sq[2]) + SQ_W'(sq[3]);
    end
  end

  assign xs[0] = sum;
  assign rs[0] = '0;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_root
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - j));
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] x_q, r_q;
    assign trial = rs[j] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (xs[j] >= trial) begin
          x_q <= xs[j] - trial;
          r_q <= (rs[j] >> 1) + BIT;
        end else begin
          x_q <= xs[j];
          r_q <= rs[j] >> 1;
        end
      end
    end
    assign xs[j+1] = x_q;
    assign rs[j+1] = r_q;
  end

  assign vout = vs[DEPTH-1];
  assign side_out = ss[DEPTH-1];
  assign nrm_out = ns[DEPTH-1];
  assign root = rs[ROOT_W][ROOT_W-1:0];
endmodule

@@ rtl/rmq_div.sv @@
// Rounded division of the scaled magnitudes by the norm, one quotient bit per stage.
module rmq_div #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic vin,
  input  rmq_pkg::side_t side_in,
  input  rmq_pkg::nrm_vec_t nrm_in,
  input  logic [rmq_pkg::ROOT_W-1:0] root,
  output logic vout,
  output rmq_pkg::side_t side_out,
  output rmq_pkg::quo_vec_t quo,
  output logic [3:0] ovf
);
  import rmq_pkg::*;

  localparam int DEPTH = QUO_W + 1;

  logic vs [DEPTH];
  side_t ss [DEPTH];
  logic [ROOT_W-1:0] ns [DEPTH];
  logic [3:0] os [DEPTH];
  logic [3:0][NUM_W-1:0] rem [DEPTH];
  quo_vec_t qs [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vs[k] <= 1'b0;
    end else if (en) begin
      vs[0] <= vin;
      for (int k = 1; k < DEPTH; k++) vs[k] <= vs[k-1];
    end
  end

  always_ff @(posedge clk) begin
    logic [NUM_W-1:0] num;
    if (en) begin
      ss[0] <= side_in;
      ns[0] <= root;
      qs[0] <= '0;
      for (int i = 0; i < 4; i++) begin
        num = (NUM_W'(nrm_in[i]) << FRAC_BITS) + NUM_W'(root >> 1);
        rem[0][i] <= num;
        os[0][i] <= num >= (NUM_W'(root) << QUO_W);
      end
      for (int k = 1; k < DEPTH; k++) begin
        ss[k] <= ss[k-1];
        ns[k] <= ns[k-1];
        os[k] <= os[k-1];
        for (int i = 0; i < 4; i++) begin
          if (rem[k-1][i] >= (NUM_W'(ns[k-1]) << (QUO_W - k))) begin
            rem[k][i] <= rem[k-1][i] - (NUM_W'(ns[k-1]) << (QUO_W - k));
            qs[k][i] <= qs[k-1][i] | (QUO_W'(1) << (QUO_W - k));
          end else begin
            rem[k][i] <= rem[k-1][i];
            qs[k][i] <= qs[k-1][i];
          end
        end
      end
    end
  end

  assign vout = vs[DEPTH-1];
  assign side_out = ss[DEPTH-1];
  assign quo = qs[DEPTH-1];
  assign ovf = os[DEPTH-1];
endmodule

@@ rtl/rotation_matrix_to_quaternion_core.sv @@
// Top level of the rotation matrix to quaternion core.
// Converts one Q2.14 rotation matrix per clock, unless stalled, into a unit quaternion,
// with the branch taken and a flag for a non-positive chosen term (outputs then saturate
// by sign). Three front stages pick the branch and scale the component vector, two form
// the sum of squares, 31 stages take the square root one result bit each, 18 stages
// divide (the first adds the rounding term, each later one yields a quotient bit), and a
// final saturation register drives the outputs. An output stall holds the whole pipeline.
module rotation_matrix_to_quaternion_core #(
  parameter int FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z,
  output logic [1:0] branch_used,
  output logic degenerate
);
  import rmq_pkg::*;

  logic en;
  logic f_v, s_v, d_v;
  side_t f_side, s_side, d_side;
  nrm_vec_t f_nrm, s_nrm;
  logic [ROOT_W-1:0] s_root;
  quo_vec_t d_quo;
  logic [3:0] d_ovf;
  logic [3:0][15:0] res;

  assign in_stall = out_valid && out_stall;
  assign en = !in_stall;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .vin(in_valid),
    .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
    .m20(m20), .m21(m21), .m22(m22),
    .vout(f_v), .side_out(f_side), .nrm_out(f_nrm)
  );

  rmq_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .vin(f_v), .side_in(f_side), .nrm_in(f_nrm),
    .vout(s_v), .side_out(s_side), .nrm_out(s_nrm), .root(s_root)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .en(en), .vin(s_v), .side_in(s_side), .nrm_in(s_nrm),
    .root(s_root), .vout(d_v), .side_out(d_side), .quo(d_quo), .ovf(d_ovf)
  );

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (d_side.degen) begin
        if (d_side.neg[i]) res[i] = 16'h8000;
        else if (d_side.nz[i]) res[i] = 16'h7fff;
        else res[i] = 16'h0000;
      end else if (d_side.neg[i] && (d_ovf[i] || d_quo[i] != '0)) begin
        if (d_ovf[i] || d_quo[i] > QUO_W'(32768)) res[i] = 16'h8000;
        else res[i] = 16'(-d_quo[i]);
      end else begin
        if (d_ovf[i] || d_quo[i] > QUO_W'(32767)) res[i] = 16'h7fff;
        else res[i] = d_quo[i][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quat_w <= res[0];
      quat_x <= res[1];
      quat_y <= res[2];
      quat_z <= res[3];
      branch_used <= d_side.br;
      degenerate <= d_side.degen;
    end
  end
endmodule

@@ rtl/rmq_checker.sv @@
// Port-level assertion checker for the rotation matrix to quaternion core.
`include "rotation_matrix_to_quaternion_core_assert.svh"

module rmq_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_stall,
  input logic signed [15:0] quat_w,
  input logic signed [15:0] quat_x,
  input logic signed [15:0] quat_y,
  input logic signed [15:0] quat_z,
  input logic [1:0] branch_used,
  input logic degenerate
);
  import rmq_pkg::*;

  `RMQ_ASSERT_NEXT(a_reset_clears, rst, !out_valid)
  `RMQ_ASSERT_IMPL(a_stall_holds, $past(out_valid && out_stall) && !rst,
    out_valid && $stable(quat_w) && $stable(quat_x) && $stable(quat_y) && $stable(quat_z) && $stable(branch_used) && $stable(degenerate))
  `RMQ_ASSERT_IMPL(a_degen_branch, out_valid && degenerate, branch_used != BR_TRACE)
  `RMQ_ASSERT_IMPL(a_degen_sat, out_valid && degenerate,
    (quat_w == 16'sh7fff || quat_w == -16'sh8000 || quat_w == 16'sh0000) &&
    (quat_x == 16'sh7fff || quat_x == -16'sh8000 || quat_x == 16'sh0000))
endmodule

bind rotation_matrix_to_quaternion_core rmq_checker u_rmq_checker (.*);
